// ===== rtl/ppsw_pkg.sv =====
// Package: shared constants and tables for the steering watchdog block.
package ppsw_pkg;

  localparam int unsigned WorldWidthDefault = 24;
  localparam int unsigned AtanIterDefault = 12;

  localparam int unsigned LimitQ16 = 21758;
  localparam int unsigned KSat = 524288;
  localparam int unsigned SweepCap = 2048;
  localparam int unsigned SweepYaw = 307;
  localparam int unsigned LookMin = 2048;
  localparam int unsigned LookMax = 9216;

  localparam logic [2:0] REG_MAX_SPEED = 3'd0;
  localparam logic [2:0] REG_MIN_SPEED = 3'd1;
  localparam logic [2:0] REG_CREEP_SPEED = 3'd2;
  localparam logic [2:0] REG_STRAIGHT_CREEP = 3'd3;
  localparam logic [2:0] REG_STUCK_CYCLES = 3'd4;
  localparam logic [2:0] REG_STUCK_DISTANCE = 3'd5;
  localparam logic [2:0] REG_LONG_WINDOW = 3'd6;
  localparam logic [2:0] REG_LONG_DISTANCE = 3'd7;

  localparam logic [1:0] MODE_PURSUIT = 2'd0;
  localparam logic [1:0] MODE_CREEP = 2'd1;
  localparam logic [1:0] MODE_SWEEP = 2'd2;
  localparam logic [1:0] MODE_STOP = 2'd3;

  // CORDIC angle table, Q16 radians
  function automatic logic [15:0] atan_entry(input logic [3:0] i);
    logic [15:0] r;
    begin
      case (i)
        4'd0: r = 16'd51472;
        4'd1: r = 16'd30386;
        4'd2: r = 16'd16055;
        4'd3: r = 16'd8150;
        4'd4: r = 16'd4091;
        4'd5: r = 16'd2047;
        4'd6: r = 16'd1024;
        4'd7: r = 16'd512;
        4'd8: r = 16'd256;
        4'd9: r = 16'd128;
        4'd10: r = 16'd64;
        4'd11: r = 16'd32;
        4'd12: r = 16'd16;
        4'd13: r = 16'd8;
        4'd14: r = 16'd4;
        default: r = 16'd2;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/ppsw_divider.sv =====
// Module: restoring unsigned divider, one quotient bit per cycle.
module ppsw_divider import ppsw_pkg::*; #(
  parameter int unsigned NumWidth = 48,
  parameter int unsigned DenWidth = 34
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NumWidth-1:0] numer,
  input  logic [DenWidth-1:0] denom,
  output logic                done,
  output logic [NumWidth-1:0] quot
);

  localparam int unsigned CntWidth = $clog2(NumWidth + 1);

  logic [DenWidth:0]   rem;
  logic [DenWidth:0]   rem_shift;
  logic [NumWidth-1:0] q;
  logic [CntWidth-1:0] count;
  logic                busy;

  assign rem_shift = {rem[DenWidth-1:0], q[NumWidth-1]};

  // Shift one numerator bit in, subtract when the remainder allows
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CntWidth'(NumWidth);
        q <= numer;
        rem <= '0;
      end else if (busy) begin
        if (rem_shift >= {1'b0, denom}) begin
          rem <= rem_shift - {1'b0, denom};
          q <= {q[NumWidth-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          q <= {q[NumWidth-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule

// ===== rtl/ppsw_watchdog.sv =====
// Module: short- and long-term no-progress watchdog with a stop latch.
module ppsw_watchdog import ppsw_pkg::*; #(
  parameter int unsigned WorldWidth = WorldWidthDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [WorldWidth-1:0] wx,
  input  logic signed [WorldWidth-1:0] wy,
  input  logic [7:0]                   stuck_cycles,
  input  logic [11:0]                  stuck_distance,
  input  logic [8:0]                   long_window,
  input  logic [11:0]                  long_distance,
  output logic                         busy,
  output logic                         stop_latched
);

  typedef enum logic [4:0] {
    W_IDLE  = 5'b00001,
    W_SHORT = 5'b00010,
    W_SCMP  = 5'b00100,
    W_LONG  = 5'b01000,
    W_LCMP  = 5'b10000
  } wstate_t;

  wstate_t state;
  logic anchor_valid, snap_valid;
  logic signed [WorldWidth-1:0] anchor_px, anchor_py, snap_px, snap_py;
  logic [7:0] anchor_age;
  logic [8:0] snap_age;
  logic signed [WorldWidth-1:0] ref_x, ref_y;
  logic signed [WorldWidth:0] dx, dy;
  logic [WorldWidth:0] adx, ady;
  logic [15:0] cx, cy;
  logic [32:0] d2;
  logic [23:0] thresh;

  // Shared distance unit: clamped axis differences, squared and summed
  assign ref_x = (state == W_SHORT) ? anchor_px : snap_px;
  assign ref_y = (state == W_SHORT) ? anchor_py : snap_py;
  assign dx = {wx[WorldWidth-1], wx} - {ref_x[WorldWidth-1], ref_x};
  assign dy = {wy[WorldWidth-1], wy} - {ref_y[WorldWidth-1], ref_y};
  assign adx = dx[WorldWidth] ? (WorldWidth+1)'(-dx) : (WorldWidth+1)'(dx);
  assign ady = dy[WorldWidth] ? (WorldWidth+1)'(-dy) : (WorldWidth+1)'(dy);
  assign cx = (adx > (WorldWidth+1)'(65535)) ? 16'hFFFF : adx[15:0];
  assign cy = (ady > (WorldWidth+1)'(65535)) ? 16'hFFFF : ady[15:0];

  logic [32:0] d2_reg;
  logic [23:0] thresh_reg;
  logic [7:0]  age_inc;
  logic [8:0]  snap_inc;
  assign age_inc = (anchor_age < 8'd255) ? anchor_age + 8'd1 : anchor_age;
  assign snap_inc = (snap_age < 9'd511) ? snap_age + 9'd1 : snap_age;
  assign d2 = 33'(cx * cx) + 33'(cy * cy);
  assign thresh = (state == W_SHORT) ? stuck_distance * stuck_distance
                                     : long_distance * long_distance;

  assign busy = (state != W_IDLE);

  // Sequence: short check (skipped while no anchor is held), then long check unless the short check latches a stop
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      stop_latched <= 1'b0;
      anchor_valid <= 1'b0;
      snap_valid <= 1'b0;
      anchor_age <= '0;
      snap_age <= '0;
      anchor_px <= '0;
      anchor_py <= '0;
      snap_px <= '0;
      snap_py <= '0;
    end else begin
      unique case (state)
        W_IDLE: begin
          if (start) begin
            if (!anchor_valid) begin
              anchor_px <= wx;
              anchor_py <= wy;
              anchor_valid <= 1'b1;
              anchor_age <= '0;
              state <= W_LONG;
            end else begin
              state <= W_SHORT;
            end
          end
        end
        W_SHORT: begin
          d2_reg <= d2;
          thresh_reg <= thresh;
          anchor_age <= age_inc;
          state <= W_SCMP;
        end
        W_SCMP: begin
          if (d2_reg >= 33'(thresh_reg)) begin
            anchor_px <= wx;
            anchor_py <= wy;
            anchor_age <= '0;
            state <= W_LONG;
          end else if (anchor_age > stuck_cycles) begin
            stop_latched <= 1'b1;
            state <= W_IDLE;
          end else begin
            state <= W_LONG;
          end
        end
        W_LONG: begin
          if (!snap_valid) begin
            snap_px <= wx;
            snap_py <= wy;
            snap_valid <= 1'b1;
            snap_age <= '0;
            state <= W_IDLE;
          end else begin
            snap_age <= snap_inc;
            d2_reg <= d2;
            thresh_reg <= thresh;
            state <= (snap_inc >= long_window) ? W_LCMP : W_IDLE;
          end
        end
        W_LCMP: begin
          if (d2_reg < 33'(thresh_reg)) begin
            stop_latched <= 1'b1;
          end else begin
            snap_px <= wx;
            snap_py <= wy;
            snap_age <= '0;
          end
          state <= W_IDLE;
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/pure_pursuit_steering_watchdog_top.sv =====
// Top level: pure-pursuit steering command with no-progress watchdog.
//
// One item per path point, accepted only while the block is idle. A plain
// point item is captured, then takes one squared-radius step. The pose
// item of a cycle with a valid pose also runs the watchdog (short check,
// then long check) unless a stop is latched. The last item of a pursuit
// cycle runs a bit-serial divide for curvature, a CORDIC, a reciprocal
// multiply for the speed blend and a multiply step. Empty-path and stop
// results skip these steps. The result sits in an output register, and the
// block waits there until it is taken.
module pure_pursuit_steering_watchdog_top import ppsw_pkg::*; #(
  parameter int unsigned WORLD_WIDTH = WorldWidthDefault,
  parameter int unsigned ATAN_ITERATIONS = AtanIterDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [13:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          first_of_cycle,
  input  logic                          pose_valid,
  input  logic signed [WORLD_WIDTH-1:0] world_x,
  input  logic signed [WORLD_WIDTH-1:0] world_y,
  input  logic                          path_empty,
  input  logic signed [15:0]            point_x,
  input  logic signed [15:0]            point_y,
  input  logic                          last_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [13:0]                   speed_cmd,
  output logic signed [15:0]            yaw_rate_cmd,
  output logic signed [15:0]            target_x,
  output logic signed [15:0]            target_y,
  output logic [1:0]                    drive_mode
);

  localparam int unsigned ItWidth = $clog2(ATAN_ITERATIONS + 1);
  // ceil(2^42 / 10879), with 21758 = 2 * 10879
  localparam logic [28:0] BlendRecip = 29'd404269374;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_WDOG   = 12'b000000000010,
    S_POINT  = 12'b000000000100,
    S_EMIT   = 12'b000000001000,
    S_KDIV   = 12'b000000010000,
    S_KWAIT  = 12'b000000100000,
    S_ATAN   = 12'b000001000000,
    S_SDIV   = 12'b000010000000,
    S_SWAIT  = 12'b000100000000,
    S_YAW    = 12'b001000000000,
    S_YAWSAT = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [13:0] max_speed, min_speed, creep_speed;
  logic [9:0]  straight_creep_cycles;
  logic [7:0]  stuck_cycles;
  logic [11:0] stuck_distance, long_distance;
  logic [8:0]  long_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= 14'd5120;
      min_speed <= 14'd2048;
      creep_speed <= 14'd512;
      straight_creep_cycles <= 10'd60;
      stuck_cycles <= 8'd90;
      stuck_distance <= 12'd77;
      long_window <= 9'd300;
      long_distance <= 12'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_SPEED: max_speed <= cfg_data;
        REG_MIN_SPEED: min_speed <= cfg_data;
        REG_CREEP_SPEED: creep_speed <= cfg_data;
        REG_STRAIGHT_CREEP: straight_creep_cycles <= cfg_data[9:0];
        REG_STUCK_CYCLES: stuck_cycles <= cfg_data[7:0];
        REG_STUCK_DISTANCE: stuck_distance <= cfg_data[11:0];
        REG_LONG_WINDOW: long_window <= cfg_data[8:0];
        REG_LONG_DISTANCE: long_distance <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Captured item
  logic        it_empty, it_last;
  logic signed [WORLD_WIDTH-1:0] it_wx, it_wy;
  logic signed [15:0] it_px, it_py;

  logic wd_start, wd_busy, stop_latched;
  ppsw_watchdog #(.WorldWidth(WORLD_WIDTH)) u_wdog (
    .clk, .rst, .start(wd_start), .wx(it_wx), .wy(it_wy),
    .stuck_cycles, .stuck_distance, .long_window, .long_distance,
    .busy(wd_busy), .stop_latched
  );

  // Divider for the curvature quotient
  logic        div_start, div_done;
  logic [47:0] div_num, div_quot;
  logic [33:0] div_den;
  ppsw_divider #(.NumWidth(48), .DenWidth(34)) u_div (
    .clk, .rst, .start(div_start), .numer(div_num), .denom(div_den),
    .done(div_done), .quot(div_quot)
  );

  logic        target_found, have_point;
  logic signed [15:0] held_px, held_py;
  logic [9:0]  empty_run;
  logic [13:0] previous_speed;

  // Working registers
  logic [31:0] r2;
  logic signed [20:0] k;
  logic signed [22:0] cx, cy;
  logic [16:0] cz_pos;
  logic signed [18:0] cz;
  logic [ItWidth-1:0] iter;
  logic [13:0] speed;
  logic signed [34:0] prod;
  logic k_neg;
  logic [13:0] o_speed;
  logic signed [15:0] o_yaw, o_tx, o_ty;
  logic [1:0] o_mode;
  logic [28:0] blend_num;

  function automatic logic [15:0] held_py_abs(input logic signed [15:0] v);
    begin
      return v[15] ? 16'(-v) : 16'(v);
    end
  endfunction

  // Point squared radius and lookahead test
  logic [13:0] look;
  logic [31:0] pr2;
  logic [27:0] look2;
  assign look = (previous_speed < 14'(LookMin)) ? 14'(LookMin) :
                (previous_speed > 14'(LookMax)) ? 14'(LookMax) : previous_speed;
  assign pr2 = 32'(it_px * it_px) + 32'(it_py * it_py);
  assign look2 = look * look;

  // CORDIC step with shifts rounding toward zero
  logic signed [22:0] sx, sy, nx, ny;
  logic [15:0] ang;
  assign sx = (cx < 0) ? -((-cx) >>> iter) : (cx >>> iter);
  assign sy = (cy < 0) ? -((-cy) >>> iter) : (cy >>> iter);
  assign ang = atan_entry(iter[3:0]);

  // Sweep speed: floor(n*256/125) via reciprocal multiply (n < 1024)
  logic [9:0]  sweep_n;
  logic [17:0] sweep_num;
  logic [17:0] sweep_q;
  logic [10:0] ticks;
  logic [14:0] sweep_sum;
  logic [9:0]  run_inc;
  assign run_inc = (empty_run < 10'd1023) ? empty_run + 10'd1 : empty_run;
  assign sweep_n = run_inc - straight_creep_cycles;
  assign sweep_num = {sweep_n, 8'd0};
  assign sweep_q = 18'((36'(sweep_num) * 36'd134218) >> 24);
  assign ticks = (18'(sweep_q * 18'd125 + 18'd125) <= sweep_num) ?
                 11'(sweep_q + 18'd1) : 11'(sweep_q);
  assign sweep_sum = 15'(creep_speed) + 15'(ticks);

  // Blend difference, signed 15 bits
  logic signed [14:0] span;
  logic [14:0] aspan;
  assign span = $signed({1'b0, max_speed}) - $signed({1'b0, min_speed});
  assign aspan = span[14] ? 15'(-span) : 15'(span);

  // Blend quotient |span|*z / LIMIT by reciprocal multiply
  logic [56:0] blend_prod;
  logic [13:0] blend_q;
  assign blend_prod = 57'(blend_num[28:1]) * 57'(BlendRecip);
  assign blend_q = blend_prod[55:42];

  logic signed [35:0] yaw_q;
  assign yaw_q = (prod < 0) ? -36'((-36'(prod)) >>> 16) : 36'(prod >>> 16);

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign speed_cmd = o_speed;
  assign yaw_rate_cmd = o_yaw;
  assign target_x = o_tx;
  assign target_y = o_ty;
  assign drive_mode = o_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wd_start <= 1'b0;
      div_start <= 1'b0;
      target_found <= 1'b0;
      have_point <= 1'b0;
      held_px <= '0;
      held_py <= '0;
      empty_run <= '0;
      previous_speed <= '0;
    end else begin
      wd_start <= 1'b0;
      div_start <= 1'b0;
      unique case (state)
        // Take an item, clear accumulators on the first one
        S_IDLE: begin
          if (in_valid) begin
            it_wx <= world_x;
            it_wy <= world_y;
            it_empty <= path_empty;
            it_px <= point_x;
            it_py <= point_y;
            it_last <= last_point;
            if (first_of_cycle) begin
              target_found <= 1'b0;
              have_point <= 1'b0;
              held_px <= '0;
              held_py <= '0;
            end
            if (first_of_cycle && pose_valid && !stop_latched) begin
              wd_start <= 1'b1;
              state <= S_WDOG;
            end else begin
              state <= S_POINT;
            end
          end
        end
        S_WDOG: begin
          if (!wd_start && !wd_busy) state <= S_POINT;
        end
        // Hold the first point beyond the lookahead, else the last point seen
        S_POINT: begin
          if (!it_empty) begin
            have_point <= 1'b1;
            if (!target_found) begin
              held_px <= it_px;
              held_py <= it_py;
              if ({pr2, 4'd0} >= 36'(look2)) target_found <= 1'b1;
            end
          end
          state <= it_last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          o_tx <= '0;
          o_ty <= '0;
          o_yaw <= '0;
          o_speed <= '0;
          if (stop_latched) begin
            o_mode <= MODE_STOP;
            state <= S_OUT;
          end else if (!have_point) begin
            empty_run <= run_inc;
            if (run_inc <= straight_creep_cycles) begin
              o_speed <= creep_speed;
              o_mode <= MODE_CREEP;
            end else begin
              o_speed <= (sweep_sum > 15'(SweepCap)) ? 14'(SweepCap) : sweep_sum[13:0];
              o_yaw <= 16'(SweepYaw);
              o_mode <= MODE_SWEEP;
            end
            state <= S_OUT;
          end else begin
            empty_run <= '0;
            o_tx <= held_px;
            o_ty <= held_py;
            o_mode <= MODE_PURSUIT;
            r2 <= 32'(held_px * held_px) + 32'(held_py * held_py);
            k_neg <= held_py[15];
            state <= S_KDIV;
          end
          target_found <= 1'b0;
          have_point <= 1'b0;
          held_px <= '0;
          held_py <= '0;
        end
        // Curvature magnitude |y|*2^25 / r2
        S_KDIV: begin
          if (r2 == '0) begin
            k <= '0;
            cx <= 23'sd65536;
            cy <= '0;
            cz <= '0;
            iter <= '0;
            state <= S_ATAN;
          end else begin
            div_num <= {7'd0, (held_py_abs(o_ty)), 25'd0};
            div_den <= 34'(r2);
            div_start <= 1'b1;
            state <= S_KWAIT;
          end
        end
        S_KWAIT: begin
          if (div_done) begin
            logic [20:0] km;
            logic [23:0] m31;
            logic [45:0] mq5;
            logic [22:0] um;
            km = (div_quot > 48'(KSat)) ? 21'(KSat) : div_quot[20:0];
            // |k|*31/20 as ((|k|*31) >> 2) / 5 by reciprocal multiply
            m31 = 24'(km) * 24'd31;
            mq5 = 46'(m31[23:2]) * 46'd13421773;
            um = 23'(mq5 >> 26);
            k <= k_neg ? -$signed({1'b0, km[19:0]}) - (km[20] ? 21'sd0 : 21'sd0)
                       : $signed(km);
            cx <= 23'sd65536;
            cy <= $signed(um);
            cz <= '0;
            iter <= '0;
            state <= S_ATAN;
          end
        end
        // One CORDIC vectoring step per cycle
        S_ATAN: begin
          if (iter == ItWidth'(ATAN_ITERATIONS)) begin
            cz_pos <= (cz < 0) ? '0 : 17'(cz);
            state <= S_SDIV;
          end else begin
            if (cy > 0) begin
              cx <= cx + sy;
              cy <= cy - sx;
              cz <= cz + $signed({3'd0, ang});
            end else begin
              cx <= cx - sy;
              cy <= cy + sx;
              cz <= cz - $signed({3'd0, ang});
            end
            iter <= iter + 1'b1;
          end
        end
        // Speed blend: |span|*z / LIMIT, or min_speed once z reaches LIMIT
        S_SDIV: begin
          if (cz_pos >= 17'(LimitQ16)) begin
            speed <= min_speed;
            state <= S_YAW;
          end else begin
            blend_num <= 29'(aspan * cz_pos);
            state <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          speed <= span[14] ? 14'(max_speed + blend_q)
                            : 14'(max_speed - blend_q);
          state <= S_YAW;
        end
        S_YAW: begin
          prod <= $signed({1'b0, speed}) * k;
          state <= S_YAWSAT;
        end
        S_YAWSAT: begin
          o_speed <= speed;
          previous_speed <= speed;
          o_yaw <= (yaw_q > 36'sd32767) ? 16'sh7FFF :
                   (yaw_q < -36'sd32768) ? 16'sh8000 : 16'(yaw_q);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/ppsw_checker.sv =====
// Checker: watches the item channels, predicts each steering command and compares it.
module ppsw_checker import ppsw_pkg::*; #(
  parameter int unsigned WORLD_WIDTH = WorldWidthDefault,
  parameter int unsigned ATAN_ITERATIONS = AtanIterDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [13:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          first_of_cycle,
  input  logic                          pose_valid,
  input  logic signed [WORLD_WIDTH-1:0] world_x,
  input  logic signed [WORLD_WIDTH-1:0] world_y,
  input  logic                          path_empty,
  input  logic signed [15:0]            point_x,
  input  logic signed [15:0]            point_y,
  input  logic                          last_point,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [13:0]                   speed_cmd,
  input  logic signed [15:0]            yaw_rate_cmd,
  input  logic signed [15:0]            target_x,
  input  logic signed [15:0]            target_y,
  input  logic [1:0]                    drive_mode,
  output int                            errors,
  output int                            pending
);

  typedef struct packed {
    logic [13:0]        speed;
    logic signed [15:0] yaw;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic [1:0]         mode;
  } command_t;

  command_t cmd_q[$];

  // Q16 arctangent of 2^-i
  longint angle_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};

  logic [13:0] max_spd, min_spd, creep_spd;
  logic [9:0]  straight_n;
  logic [7:0]  stuck_n;
  logic [11:0] stuck_dist;
  logic [8:0]  long_win;
  logic [11:0] long_dist;

  bit     stopped, anc_ok, snap_ok, found, have_pt;
  longint anc_x, anc_y, snap_x, snap_y, held_x, held_y, prev_speed;
  int     anc_age, snap_age, empty_run;

  function automatic longint shift_to_zero(longint v, int s);
    return v >= 0 ? (v >>> s) : -((-v) >>> s);
  endfunction

  // Squared displacement with each axis clamped to 16 bits
  function automatic longint disp_sq(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx > 65535) dx = 65535;
    if (dy > 65535) dy = 65535;
    return dx * dx + dy * dy;
  endfunction

  // CORDIC vectoring angle of (1, u) in Q16
  function automatic longint steer_angle(longint u);
    longint x, y, z, nx, ny;
    x = 65536;
    y = u;
    z = 0;
    for (int i = 0; i < ATAN_ITERATIONS && i < 16; i++) begin
      if (y > 0) begin
        nx = x + shift_to_zero(y, i);
        ny = y - shift_to_zero(x, i);
        z += angle_tab[i];
      end else begin
        nx = x - shift_to_zero(y, i);
        ny = y + shift_to_zero(x, i);
        z -= angle_tab[i];
      end
      x = nx;
      y = ny;
    end
    return z < 0 ? 0 : z;
  endfunction

  task automatic clear_points();
    found = 0;
    have_pt = 0;
    held_x = 0;
    held_y = 0;
  endtask

  task automatic reset_model();
    max_spd = 5120;
    min_spd = 2048;
    creep_spd = 512;
    straight_n = 60;
    stuck_n = 90;
    stuck_dist = 77;
    long_win = 300;
    long_dist = 256;
    stopped = 0;
    anc_ok = 0;
    snap_ok = 0;
    anc_x = 0;
    anc_y = 0;
    snap_x = 0;
    snap_y = 0;
    anc_age = 0;
    snap_age = 0;
    empty_run = 0;
    prev_speed = 0;
    clear_points();
  endtask

  task automatic write_reg(logic [2:0] idx, logic [13:0] val);
    case (idx)
      REG_MAX_SPEED:      max_spd = val;
      REG_MIN_SPEED:      min_spd = val;
      REG_CREEP_SPEED:    creep_spd = val;
      REG_STRAIGHT_CREEP: straight_n = val[9:0];
      REG_STUCK_CYCLES:   stuck_n = val[7:0];
      REG_STUCK_DISTANCE: stuck_dist = val[11:0];
      REG_LONG_WINDOW:    long_win = val[8:0];
      default:            long_dist = val[11:0];
    endcase
  endtask

  // Short-term check first; a latch skips the long-term check
  task automatic run_watchdog(longint wx, longint wy);
    longint lim;
    if (!anc_ok) begin
      anc_x = wx;
      anc_y = wy;
      anc_ok = 1;
      anc_age = 0;
    end else begin
      if (anc_age < 255) anc_age++;
      lim = longint'(stuck_dist) * longint'(stuck_dist);
      if (disp_sq(wx, wy, anc_x, anc_y) >= lim) begin
        anc_x = wx;
        anc_y = wy;
        anc_age = 0;
      end else if (anc_age > int'(stuck_n)) begin
        stopped = 1;
        return;
      end
    end
    if (!snap_ok) begin
      snap_x = wx;
      snap_y = wy;
      snap_ok = 1;
      snap_age = 0;
    end else begin
      if (snap_age < 511) snap_age++;
      if (snap_age >= int'(long_win)) begin
        lim = longint'(long_dist) * longint'(long_dist);
        if (disp_sq(wx, wy, snap_x, snap_y) < lim) begin
          stopped = 1;
          return;
        end
        snap_x = wx;
        snap_y = wy;
        snap_age = 0;
      end
    end
  endtask

  // Advance the model by one item; queue a command on the last item
  task automatic take_item(bit f, bit pv, longint wx, longint wy, bit pe,
                           longint px, longint py, bit lp);
    longint lq, r2, k, u, z, spd, yaw, tx, ty, n;
    command_t c;
    if (f) begin
      clear_points();
      if (!stopped && pv) run_watchdog(wx, wy);
    end
    if (!pe) begin
      have_pt = 1;
      if (!found) begin
        lq = prev_speed;
        r2 = px * px + py * py;
        if (lq < longint'(LookMin)) lq = LookMin;
        if (lq > longint'(LookMax)) lq = LookMax;
        held_x = px;
        held_y = py;
        if (16 * r2 >= lq * lq) found = 1;
      end
    end
    if (!lp) return;
    spd = 0;
    yaw = 0;
    tx = 0;
    ty = 0;
    if (stopped) begin
      c.mode = MODE_STOP;
    end else if (!have_pt) begin
      if (empty_run < 1023) empty_run++;
      if (empty_run <= int'(straight_n)) begin
        spd = creep_spd;
        c.mode = MODE_CREEP;
      end else begin
        n = empty_run - int'(straight_n);
        spd = longint'(creep_spd) + (n * 256) / 125;
        if (spd > longint'(SweepCap)) spd = SweepCap;
        yaw = SweepYaw;
        c.mode = MODE_SWEEP;
      end
    end else begin
      empty_run = 0;
      tx = held_x;
      ty = held_y;
      r2 = tx * tx + ty * ty;
      k = 0;
      if (r2 > 0) begin
        k = (ty * (longint'(1) << 25)) / r2;
        if (k > longint'(KSat)) k = KSat;
        if (k < -longint'(KSat)) k = -longint'(KSat);
      end
      u = ((k < 0 ? -k : k) * 31) / 20;
      z = steer_angle(u);
      if (z >= longint'(LimitQ16))
        spd = min_spd;
      else
        spd = longint'(max_spd) -
              ((longint'(max_spd) - longint'(min_spd)) * z) / longint'(LimitQ16);
      yaw = (spd * k) / 65536;
      if (yaw > 32767) yaw = 32767;
      if (yaw < -32768) yaw = -32768;
      prev_speed = spd & 16'h3FFF;
      c.mode = MODE_PURSUIT;
    end
    clear_points();
    c.speed = spd[13:0];
    c.yaw = yaw[15:0];
    c.tx = tx[15:0];
    c.ty = ty[15:0];
    cmd_q.push_back(c);
  endtask

  task automatic check_command();
    command_t c;
    if (cmd_q.size() == 0) begin
      $display("%0t: unexpected command speed=%0d yaw=%0d target=(%0d,%0d) mode=%0d",
               $time, speed_cmd, yaw_rate_cmd, target_x, target_y, drive_mode);
      errors++;
      return;
    end
    c = cmd_q.pop_front();
    if (speed_cmd !== c.speed) begin
      $display("%0t: speed_cmd expected %0d actual %0d", $time, c.speed, speed_cmd);
      errors++;
    end
    if (yaw_rate_cmd !== c.yaw) begin
      $display("%0t: yaw_rate_cmd expected %0d actual %0d", $time, c.yaw, yaw_rate_cmd);
      errors++;
    end
    if (target_x !== c.tx) begin
      $display("%0t: target_x expected %0d actual %0d", $time, c.tx, target_x);
      errors++;
    end
    if (target_y !== c.ty) begin
      $display("%0t: target_y expected %0d actual %0d", $time, c.ty, target_y);
      errors++;
    end
    if (drive_mode !== c.mode) begin
      $display("%0t: drive_mode expected %0d actual %0d", $time, c.mode, drive_mode);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    reset_model();
  end

  // Compare results before taking new items at the same edge
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      cmd_q.delete();
    end else begin
      if (cfg_we) write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) check_command();
      if (in_valid && in_ready)
        take_item(first_of_cycle, pose_valid, longint'(world_x), longint'(world_y),
                  path_empty, longint'(point_x), longint'(point_y), last_point);
    end
    pending <= cmd_q.size();
  end

endmodule

// ===== tb/tb_pure_pursuit_steering_watchdog_top.sv =====
// Testbench top: drives item cycles and register settings, and reports the verdict.
module tb_pure_pursuit_steering_watchdog_top;
  import ppsw_pkg::*;

  localparam int unsigned WW = WorldWidthDefault;
  localparam int NumItems = 1500;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_we = 0;
  logic [2:0]           cfg_index = REG_MAX_SPEED;
  logic [13:0]          cfg_data = 0;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic                 first_of_cycle = 0;
  logic                 pose_valid = 0;
  logic signed [WW-1:0] world_x = 0;
  logic signed [WW-1:0] world_y = 0;
  logic                 path_empty = 0;
  logic signed [15:0]   point_x = 0;
  logic signed [15:0]   point_y = 0;
  logic                 last_point = 0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic [13:0]          speed_cmd;
  logic signed [15:0]   yaw_rate_cmd;
  logic signed [15:0]   target_x;
  logic signed [15:0]   target_y;
  logic [1:0]           drive_mode;
  int                   errors;
  int                   pending;

  int                   items_sent = 0;
  int                   burst_left = 5;
  int                   stall_style = 0;
  int                   stall_hold = 0;
  logic signed [WW-1:0] track_x, track_y;
  bit                   moving = 1;

  pure_pursuit_steering_watchdog_top dut (.*);

  ppsw_checker chk (.*);

  always #5 clk = ~clk;

  // Receiver: switch between free flow, random stalls and long stalls
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_hold <= $urandom_range(50, 300);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  initial begin
    #20000000;
    $display("pure_pursuit_steering_watchdog_top verification failed");
    $finish;
  end

  // Present one item, hold it until taken, then maybe open a gap
  task automatic send_item(bit f, bit pv, logic signed [WW-1:0] wx,
                           logic signed [WW-1:0] wy, bit pe,
                           logic signed [15:0] px, logic signed [15:0] py, bit lp);
    in_valid <= 1'b1;
    first_of_cycle <= f;
    pose_valid <= pv;
    world_x <= wx;
    world_y <= wy;
    path_empty <= pe;
    point_x <= px;
    point_y <= py;
    last_point <= lp;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 20);
    end
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 4))
      0, 1: return 16'($signed($urandom_range(0, 1200)) - 600);
      2, 3: return 16'($signed($urandom_range(0, 5200)) - 2600);
      default: return 16'($urandom);
    endcase
  endfunction

  // While moving is set, move the vehicle far enough each cycle to satisfy both watchdogs
  task automatic step_pose();
    if (moving) begin
      track_x = track_x + WW'($urandom_range(2600, 3000));
      track_y = track_y + WW'($urandom_range(0, 300)) - WW'(150);
    end
  endtask

  task automatic pursuit_cycle(int npts);
    bit pv;
    pv = ($urandom_range(0, 9) != 0);
    if (pv) step_pose();
    for (int i = 0; i < npts; i++)
      send_item(i == 0, pv, pv ? track_x : WW'($urandom), pv ? track_y : WW'($urandom),
                1'b0, rand_coord(), rand_coord(), i == npts - 1);
  endtask

  task automatic empty_cycle();
    step_pose();
    send_item(1'b1, 1'b1, track_x, track_y, 1'b1, 16'($urandom), 16'($urandom), 1'b1);
  endtask

  // Wait until every command is in, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(int mx, int mn, int cr, int sc, int st, int sd, int lw, int ld);
    int vals[8];
    vals = '{mx, mn, cr, sc, st, sd, lw, ld};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= 14'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_regs();
    set_regs($urandom_range(0, 16383), $urandom_range(0, 16383), $urandom_range(0, 16383),
             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 20),
             $urandom_range(1, 254), $urandom_range(0, 2560),
             $urandom_range(1, 511), $urandom_range(0, 2560));
  endtask

  initial begin
    int r, since_cfg, latch_kind;
    track_x = WW'($urandom);
    track_y = WW'($urandom);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, empty path, zero radius, saturation, odd framing
    empty_cycle();
    step_pose();
    send_item(1, 1, track_x, track_y, 0, 16'sh7FFF, 16'sh7FFF, 1);
    step_pose();
    send_item(1, 1, track_x, track_y, 0, -16'sh8000, -16'sh8000, 1);
    step_pose();
    send_item(1, 1, track_x, track_y, 0, 16'sd0, 16'sd0, 1);
    step_pose();
    send_item(1, 1, track_x, track_y, 0, 16'sd1, 16'sd1, 1);
    step_pose();
    send_item(1, 1, track_x, track_y, 0, 16'sd100, 16'sd50, 0);
    send_item(0, 0, 0, 0, 0, 16'sd300, -16'sd200, 0);
    send_item(0, 0, 0, 0, 0, 16'sd0, -16'sh8000, 1);
    step_pose();
    send_item(1, 1, track_x, track_y, 0, 16'sd0, 16'sh7FFF, 1);
    send_item(1, 0, -WW'(1), WW'(1) << (WW - 1), 0, 16'sd600, 16'sd0, 1);
    send_item(0, 1, 0, 0, 0, 16'sd2000, 16'sd700, 0);
    send_item(0, 0, 0, 0, 0, -16'sd3000, 16'sd900, 1);
    step_pose();
    send_item(1, 1, track_x, track_y, 0, 16'sd200, 16'sd200, 0);
    step_pose();
    send_item(1, 1, track_x, track_y, 1, 16'sd0, 16'sd0, 0);
    send_item(0, 0, 0, 0, 1, 16'sd0, 16'sd0, 1);
    drain();

    // Extreme settings, then max below min
    set_regs(16383, 0, 16383, 0, 254, 2560, 1, 2560);
    for (int i = 0; i < 6; i++) empty_cycle();
    for (int i = 0; i < 10; i++) pursuit_cycle($urandom_range(1, 4));
    drain();
    set_regs(0, 16383, 0, 1023, 1, 0, 511, 0);
    for (int i = 0; i < 6; i++) empty_cycle();
    for (int i = 0; i < 10; i++) pursuit_cycle($urandom_range(1, 4));
    drain();
    set_regs(6000, 1000, 1500, 3, 40, 500, 20, 600);

    // Random cycles, mostly well formed
    since_cfg = 0;
    while (items_sent < NumItems) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        pursuit_cycle(($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                  : $urandom_range(1, 8));
      end else if (r < 75) begin
        empty_cycle();
      end else if (r < 80) begin
        repeat ($urandom_range(10, 40)) empty_cycle();
      end else if (r < 92) begin
        send_item(1'($urandom), 1'($urandom), WW'($urandom), WW'($urandom),
                  1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        send_item(0, 1, WW'($urandom), WW'($urandom), 0, rand_coord(), rand_coord(), 0);
        send_item(0, 0, 0, 0, 1'($urandom), rand_coord(), rand_coord(), 1);
      end
      if (items_sent - since_cfg > 300) begin
        drain();
        random_regs();
        since_cfg = items_sent;
      end
    end

    // Stand still until one watchdog latches, then run in the stop state
    drain();
    latch_kind = $urandom_range(0, 1);
    if (latch_kind == 0)
      set_regs(5120, 2048, 512, 10, 2, 2560, 511, 0);
    else
      set_regs(5120, 2048, 512, 10, 254, 0, 2, 2560);
    moving = 0;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0) empty_cycle();
      else pursuit_cycle($urandom_range(1, 4));
    end
    drain();
    repeat (200) @(posedge clk);

    if (errors == 0)
      $display("pure_pursuit_steering_watchdog_top verification clean");
    else
      $display("pure_pursuit_steering_watchdog_top verification failed");
    $finish;
  end

endmodule
